// File: sv/csact_pkg.sv
`timescale 1ns / 1ps
package csact_pkg;
  localparam int Sets = 256;
  localparam int Ways = 4;
  localparam int SetBits = 8;
  localparam int WayBits = 2;
  localparam int AddrBits = 32;

  typedef enum logic [1:0] {
    ST_INVALID  = 2'd0,
    ST_VALID    = 2'd1,
    ST_SHARED   = 2'd2,
    ST_MODIFIED = 2'd3
  } line_state_t;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_STORE     = 2'd1,
    CMD_SNOOP_LD  = 2'd2,
    CMD_SNOOP_ST  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_VI   = 2'd1,
    MODE_MSI  = 2'd2,
    MODE_OFF  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_INDEX  = 2'd2,
    REG_WAYS   = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_CLEAR = 2'd2
  } phase_t;

  // One way's entry: tag, state and dirty mark
  typedef struct packed {
    logic [AddrBits-1:0] tag;
    line_state_t         st;
    logic                dirty;
  } entry_t;

  typedef entry_t [Ways-1:0] set_row_t;

  // Write-back request from the control unit to the set memory
  typedef struct packed {
    logic                 we;
    logic [SetBits-1:0]   set;
    set_row_t             row;
    logic [WayBits-1:0]   ptr;
  } row_wr_t;
endpackage

// File: sv/csact_set_mem.sv
`timescale 1ns / 1ps
module csact_set_mem (
  input  logic                       clk,
  input  logic [csact_pkg::SetBits-1:0] rd_set,
  input  csact_pkg::row_wr_t         wr,
  output csact_pkg::set_row_t        rd_row,
  output logic [csact_pkg::WayBits-1:0] rd_ptr
);
  import csact_pkg::*;

  // One row per set: all ways plus the victim pointer
  set_row_t           rows [Sets];
  logic [WayBits-1:0] ptrs [Sets];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      rows[wr.set] <= wr.row;
      ptrs[wr.set] <= wr.ptr;
    end
    rd_row <= rows[rd_set];
    rd_ptr <= ptrs[rd_set];
  end
endmodule

// File: sv/coherent_set_assoc_cache_tags_core.sv
`timescale 1ns / 1ps
// Tag and state array of a 4-way, 256-set cache; none/VI/MSI protocols or off.
// Input channel in_valid/in_stall carries command and address; output channel
// out_valid/out_stall carries hit, writeback, shared_upgrade, way_used, set_used.
// Configuration: cfg_we, cfg_index, cfg_data, to be written only while idle;
// the block itself does not enforce this. The set row is read from the
// synchronous set memory at the accepting edge; the next cycle compares all
// ways, updates and writes the row back, and the result enters the output
// register at the end of that cycle. Because the next transaction is read
// only after the write-back, no forwarding is needed. in_stall is high in
// that update cycle, so a new transaction is not taken before the last one
// is written back. After reset a clearing pass writes every set row to
// invalid with zero pointers, with in_stall high during the pass.
// A stalled output holds its result, and the input is stalled as long as
// that result waits.
module coherent_set_assoc_cache_tags_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        writeback,
  output logic        shared_upgrade,
  output logic [1:0]  way_used,
  output logic [7:0]  set_used
);
  import csact_pkg::*;

  // Configuration registers
  logic [1:0] protocol_mode;
  logic [3:0] block_offset_bits, set_index_bits;
  logic [2:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= 2'd0;
      block_offset_bits <= 4'd6;
      set_index_bits <= 4'd8;
      ways_in_use <= 3'd4;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_MODE:   protocol_mode <= cfg_data[1:0];
        REG_OFFSET: block_offset_bits <= cfg_data;
        REG_INDEX:  set_index_bits <= cfg_data;
        REG_WAYS:   ways_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  phase_t phase, phase_next;
  logic [SetBits-1:0] clr_cnt;
  logic [1:0] cmd_q;
  logic [AddrBits-1:0] tag_q;
  logic [SetBits-1:0] set_q;
  logic accept;
  row_wr_t wr;
  set_row_t rd_row;
  logic [WayBits-1:0] rd_ptr;

  // Address split for the incoming transaction
  logic [3:0] ib;
  logic [4:0] shift;
  logic [AddrBits-1:0] a_sh;
  logic [SetBits-1:0] set_in;
  logic [AddrBits-1:0] tag_in;
  logic [SetBits-1:0] imask;

  always_comb begin
    ib = (set_index_bits > 4'd8) ? 4'd8 : set_index_bits;
    a_sh = address >> block_offset_bits;
    imask = SetBits'((9'd1 << ib) - 9'd1);
    set_in = a_sh[SetBits-1:0] & imask;
    shift = 5'(block_offset_bits) + 5'(ib);
    tag_in = (shift > 5'd31) ? '0 : (address >> shift);
  end

  assign in_stall = (phase != PH_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  csact_set_mem u_mem (
    .clk(clk),
    .rd_set(accept ? set_in : set_q),
    .wr(wr),
    .rd_row(rd_row),
    .rd_ptr(rd_ptr)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      tag_q <= tag_in;
      set_q <= set_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CLEAR;
      clr_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (phase == PH_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Compare and update
  logic [2:0] nw;
  logic [2:0] ptr_w;
  logic [WayBits-1:0] way, nxt;
  logic h, wbk, up, loc;
  set_row_t row;
  logic [WayBits-1:0] ptr;
  entry_t e;

  always_comb begin
    nw = (ways_in_use == 3'd0) ? 3'd1 : ((ways_in_use > 3'd4) ? 3'd4 : ways_in_use);
    // Fold a stale victim pointer into the ways in use
    ptr_w = {1'b0, rd_ptr};
    if (ptr_w >= nw) ptr_w = ptr_w - nw;
    if (ptr_w >= nw) ptr_w = ptr_w - nw;
    if (ptr_w >= nw) ptr_w = ptr_w - nw;
    way = ptr_w[WayBits-1:0];
    h = 1'b0;
    wbk = 1'b0;
    up = 1'b0;
    loc = (cmd_q == CMD_LOAD) || (cmd_q == CMD_STORE);
    if (protocol_mode != MODE_OFF) begin
      for (int i = Ways - 1; i >= 0; i--) begin
        if ((3'(i) < nw) && rd_row[i].tag == tag_q &&
            ((protocol_mode == MODE_MSI) ? (rd_row[i].st != ST_INVALID)
                                         : (rd_row[i].st == ST_VALID))) begin
          h = 1'b1;
          way = WayBits'(i);
        end
      end
    end
    // way is below nw, so the next way wraps only at nw
    nxt = (({1'b0, way} + 3'd1) == nw) ? '0 : WayBits'(way + 1'b1);
    row = rd_row;
    ptr = rd_ptr;
    e = rd_row[way];
    if (protocol_mode == MODE_NONE || protocol_mode == MODE_VI) begin
      if (h) begin
        if (loc) begin
          if (cmd_q == CMD_STORE) e.dirty = 1'b1;
          ptr = nxt;
        end else if (protocol_mode == MODE_VI) begin
          e.st = ST_INVALID;
          h = 1'b0;
          if (e.dirty) begin
            wbk = 1'b1;
            e.dirty = 1'b0;
          end
        end
      end else if (loc) begin
        wbk = e.dirty;
        e.tag = tag_q;
        e.st = ST_VALID;
        e.dirty = (cmd_q == CMD_STORE);
        ptr = nxt;
      end
    end else if (protocol_mode == MODE_MSI) begin
      if (h) begin
        unique case (cmd_t'(cmd_q))
          CMD_LOAD: ptr = nxt;
          CMD_STORE: begin
            if (e.st == ST_SHARED) begin
              e.st = ST_MODIFIED;
              h = 1'b0;
              up = 1'b1;
            end
            ptr = nxt;
          end
          CMD_SNOOP_ST: begin
            wbk = (e.st == ST_MODIFIED);
            e.st = ST_INVALID;
          end
          default: begin
            if (e.st == ST_MODIFIED) begin
              wbk = 1'b1;
              e.st = ST_SHARED;
            end
          end
        endcase
      end else if (loc) begin
        e.st = (cmd_q == CMD_LOAD) ? ST_SHARED : ST_MODIFIED;
        e.tag = tag_q;
        ptr = nxt;
      end
    end
    row[way] = e;
  end

  // Phase control and memory write
  always_comb begin
    phase_next = phase;
    wr.we = 1'b0;
    wr.set = set_q;
    wr.row = row;
    wr.ptr = ptr;
    unique case (phase)
      PH_CLEAR: begin
        wr.we = 1'b1;
        wr.set = clr_cnt;
        for (int i = 0; i < Ways; i++) begin
          wr.row[i].tag = '0;
          wr.row[i].st = ST_INVALID;
          wr.row[i].dirty = 1'b0;
        end
        wr.ptr = '0;
        if (clr_cnt == SetBits'(Sets - 1)) phase_next = PH_IDLE;
      end
      PH_IDLE: if (accept) phase_next = PH_READ;
      PH_READ: begin
        wr.we = 1'b1;
        phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (phase == PH_READ) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_READ) begin
      hit <= h;
      writeback <= wbk;
      shared_upgrade <= up;
      way_used <= way;
      set_used <= set_q;
    end
  end
endmodule

// File: sim/tb_coherent_set_assoc_cache_tags_core.sv
`timescale 1ns / 1ps
module tb_coherent_set_assoc_cache_tags_core;
  import csact_pkg::*;

  typedef struct packed {
    logic       hit;
    logic       writeback;
    logic       upgrade;
    logic [1:0] way;
    logic [7:0] set;
  } lookup_t;

  // Tag array shadow: predicts one lookup per accepted transaction
  class tag_scoreboard;
    logic [1:0]  mode;
    logic [3:0]  obits;
    logic [3:0]  ibits;
    logic [2:0]  nways;
    logic [31:0] tags [Sets*Ways];
    line_state_t lstate [Sets*Ways];
    bit          dirty [Sets*Ways];
    logic [1:0]  ptr [Sets];
    lookup_t     pending_q [$];
    int          errors;

    function new();
      mode = MODE_NONE;
      obits = 6;
      ibits = 8;
      nways = 4;
      errors = 0;
      foreach (tags[i]) begin
        tags[i] = '0;
        lstate[i] = ST_INVALID;
        dirty[i] = 0;
      end
      foreach (ptr[i]) ptr[i] = '0;
    endfunction

    function void set_reg(reg_t idx, logic [3:0] v);
      case (idx)
        REG_MODE: mode = v[1:0];
        REG_OFFSET: obits = v;
        REG_INDEX: ibits = v;
        default: nways = v[2:0];
      endcase
    endfunction

    function void note(cmd_t c, logic [31:0] a);
      int ib, nw, set, way, ln, nxt;
      logic [31:0] tg;
      bit hit, wb, up, lcl, live;
      lookup_t r;
      ib = (ibits > SetBits) ? SetBits : ibits;
      nw = (nways == 0) ? 1 : ((nways > Ways) ? Ways : nways);
      set = int'((a >> obits) & ((32'd1 << ib) - 32'd1));
      tg = a >> (obits + ib);
      way = ptr[set] % nw;
      lcl = (c == CMD_LOAD || c == CMD_STORE);
      hit = 0;
      wb = 0;
      up = 0;
      if (mode != MODE_OFF) begin
        for (int i = 0; i < nw; i++) begin
          live = (mode == MODE_MSI) ? (lstate[set*Ways+i] != ST_INVALID)
                                    : (lstate[set*Ways+i] == ST_VALID);
          if (!hit && live && tags[set*Ways+i] == tg) begin
            hit = 1;
            way = i;
          end
        end
      end
      ln = set * Ways + way;
      nxt = (way + 1) % nw;
      if (mode == MODE_NONE || mode == MODE_VI) begin
        if (hit) begin
          if (lcl) begin
            if (c == CMD_STORE) dirty[ln] = 1;
            ptr[set] = nxt;
          end else if (mode == MODE_VI) begin
            // snoop hit under VI drops the line
            lstate[ln] = ST_INVALID;
            hit = 0;
            if (dirty[ln]) begin
              wb = 1;
              dirty[ln] = 0;
            end
          end
        end else if (lcl) begin
          wb = dirty[ln];
          tags[ln] = tg;
          lstate[ln] = ST_VALID;
          dirty[ln] = (c == CMD_STORE);
          ptr[set] = nxt;
        end
      end else if (mode == MODE_MSI) begin
        if (hit) begin
          case (c)
            CMD_LOAD: ptr[set] = nxt;
            CMD_STORE: begin
              if (lstate[ln] == ST_SHARED) begin
                lstate[ln] = ST_MODIFIED;
                hit = 0;
                up = 1;
              end
              ptr[set] = nxt;
            end
            CMD_SNOOP_ST: begin
              wb = (lstate[ln] == ST_MODIFIED);
              lstate[ln] = ST_INVALID;
            end
            default: begin
              if (lstate[ln] == ST_MODIFIED) begin
                wb = 1;
                lstate[ln] = ST_SHARED;
              end
            end
          endcase
        end else if (lcl) begin
          lstate[ln] = (c == CMD_LOAD) ? ST_SHARED : ST_MODIFIED;
          tags[ln] = tg;
          ptr[set] = nxt;
        end
      end
      r.hit = hit;
      r.writeback = wb;
      r.upgrade = up;
      r.way = way[1:0];
      r.set = set[7:0];
      pending_q.push_back(r);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check(lookup_t got);
      lookup_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", got.set, 8'h0);
      end else begin
        want = pending_q.pop_front();
        if (got.hit !== want.hit) report("hit", got.hit, want.hit);
        if (got.writeback !== want.writeback) report("writeback", got.writeback, want.writeback);
        if (got.upgrade !== want.upgrade) report("shared_upgrade", got.upgrade, want.upgrade);
        if (got.way !== want.way) report("way_used", got.way, want.way);
        if (got.set !== want.set) report("set_used", got.set, want.set);
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [3:0]  cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  command = 0;
  logic [31:0] address = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        hit;
  logic        writeback;
  logic        shared_upgrade;
  logic [1:0]  way_used;
  logic [7:0]  set_used;

  tag_scoreboard sb = new();
  bit quiet = 0;

  coherent_set_assoc_cache_tags_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .address(address),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .writeback(writeback), .shared_upgrade(shared_upgrade),
    .way_used(way_used), .set_used(set_used)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: random stall, check each accepted transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check({hit, writeback, shared_upgrade, way_used, set_used});
    out_stall <= !quiet && ($urandom_range(99) < 19);
  end

  task send_item(cmd_t c, logic [31:0] a);
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1;
    command <= c;
    address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(c, a);
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_regs(logic [3:0] m, logic [3:0] o, logic [3:0] ix, logic [3:0] w);
    logic [3:0] vals [4];
    vals = '{m, o, ix, w};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(reg_t'(i[1:0]), vals[i]);
    end
    cfg_we <= 0;
  endtask

  // Mostly addresses built from a few tags and sets so lines get reused
  function logic [31:0] pick_addr();
      int ib;
      logic [31:0] tg, st, off;
      if ($urandom_range(99) < 10) return $urandom();
      ib = (sb.ibits > SetBits) ? SetBits : sb.ibits;
      tg = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom();
      st = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom();
      st = st & ((32'd1 << ib) - 1);
      off = $urandom() & ((32'd1 << sb.obits) - 1);
      return (tg << (sb.obits + ib)) | (st << sb.obits) | off;
  endfunction

  function cmd_t pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CMD_LOAD;
    if (r < 70) return CMD_STORE;
    if (r < 85) return CMD_SNOOP_LD;
    return CMD_SNOOP_ST;
  endfunction

  // mode, offset bits, index bits, ways per phase; extremes and stale pointers
  logic [3:0] phase_cfg [9][4] = '{
    '{4'd0, 4'd6, 4'd8, 4'd4},
    '{4'd2, 4'd6, 4'd8, 4'd4},
    '{4'd1, 4'd4, 4'd3, 4'd2},
    '{4'd0, 4'd0, 4'd0, 4'd1},
    '{4'd2, 4'd12, 4'd15, 4'd7},
    '{4'd2, 4'd5, 4'd2, 4'd0},
    '{4'd3, 4'd6, 4'd8, 4'd4},
    '{4'd13, 4'd12, 4'd8, 4'd12},
    '{4'd2, 4'd3, 4'd4, 4'd3}
  };

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    for (int p = 0; p < 9; p++) begin
      drain();
      write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      quiet = (p == 3);
      // directed: every command at zero, store/snoop at all ones, load/store on one line
      if (p < 3) begin
        for (int c = 0; c < 4; c++) send_item(cmd_t'(c), 32'h0);
        send_item(CMD_STORE, 32'hffff_ffff);
        send_item(CMD_SNOOP_LD, 32'hffff_ffff);
        send_item(CMD_LOAD, 32'h0000_1040);
        send_item(CMD_STORE, 32'h0000_1040);
      end
      for (int i = 0; i < 205; i++) begin
        send_item(pick_cmd(), pick_addr());
        if (p == 4 && i == 100) begin
          // hold off until the pipe is empty
          in_valid <= 0;
          while (sb.pending_q.size() != 0) @(posedge clk);
        end
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
